// ----- rtl/lbts_pkg.sv -----
package lbts_pkg;

   localparam int LEFT_W   = 10;
   localparam int TOP_W    = 7;
   localparam int WIDTH_W  = 10;
   localparam int HEIGHT_W = 7;
   localparam int AREA_W   = 16;
   localparam int POS_W    = 10;
   localparam int CX_W     = 11;
   localparam int CY_W     = 8;
   localparam int ERR_W    = 11;
   localparam int SPEED_W  = 10;
   localparam int BASE_W   = 8;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_W    = 12;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SQ_W     = 22;
   localparam int ROOT_W   = SQ_W / 2;

   localparam int FRAME_WIDTH_DEF   = 640;
   localparam int REGION_HEIGHT_DEF = 90;

   localparam logic [AREA_W-1:0] AREA_MIN_RST    = 16'd500;
   localparam logic [POS_W-1:0]  NEAR_WINDOW_RST = 10'd75;
   localparam logic [POS_W-1:0]  FAR_WINDOW_RST  = 10'd200;
   localparam logic [POS_W-1:0]  CENTER_X_RST    = 10'd320;
   localparam logic [POS_W-1:0]  ALT_LOW_RST     = 10'd50;
   localparam logic [POS_W-1:0]  ALT_HIGH_RST    = 10'd400;
   localparam logic [BASE_W-1:0] BASE_SPEED_RST  = 8'd50;

   // Reciprocal of three scaled by 2**11; exact for dividends below 2048.
   localparam logic signed [MUL_W-1:0] RECIP3 = 12'sd683;
   localparam int RECIP3_SHIFT = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_MIN    = 3'd0,
      CSR_NEAR_WINDOW = 3'd1,
      CSR_FAR_WINDOW  = 3'd2,
      CSR_CENTER_X    = 3'd3,
      CSR_ALT_LOW     = 3'd4,
      CSR_ALT_HIGH    = 3'd5,
      CSR_BASE_SPEED  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic [SQ_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

// ----- rtl/lbts_isqrt.sv -----
module lbts_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  lbts_pkg::sqrt_req_type sqrt_req,
   output lbts_pkg::sqrt_rsp_type sqrt_rsp
);
   import lbts_pkg::*;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      if (sqrt_req.start) begin
         busy_in = 1'b1;
         rem_in  = sqrt_req.value;
         root_in = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = SQ_W'({1'b0, rem_ff} - trial);
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff[ROOT_W-1:0];

endmodule

// ----- rtl/line_blob_tracker_steering_top.sv -----
// A qualifying blob item passes through CALC, SQX, SQY, ROOT_GO, ROOT and UPDATE, and
// a frame-ending item then passes CLOSE, DIV and EMIT, where its result is loaded into
// the output register once that register is free; other items are done in IDLE.
// One item is taken at a time, and a blob item waits on the 11-step square root unit.
// A pending result is held in the output register while the next item is taken.
// Synchronous active-high reset restores state, settings, tracking and output valid; datapath registers are not reset.
module line_blob_tracker_steering_top #(
   parameter int FRAME_WIDTH   = lbts_pkg::FRAME_WIDTH_DEF,
   parameter int REGION_HEIGHT = lbts_pkg::REGION_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lbts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbts_pkg::CSR_W-1:0]          csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_has_blob,
   input  logic [lbts_pkg::LEFT_W-1:0]         req_blob_left,
   input  logic [lbts_pkg::TOP_W-1:0]          req_blob_top,
   input  logic [lbts_pkg::WIDTH_W-1:0]        req_blob_width,
   input  logic [lbts_pkg::HEIGHT_W-1:0]       req_blob_height,
   input  logic [lbts_pkg::AREA_W-1:0]         req_blob_area,
   input  logic                                req_frame_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lbts_pkg::ERR_W-1:0]   rsp_steer_error,
   output logic signed [lbts_pkg::SPEED_W-1:0] rsp_left_speed,
   output logic signed [lbts_pkg::SPEED_W-1:0] rsp_right_speed,
   output logic                                rsp_main_flag
);
   import lbts_pkg::*;

   localparam logic [POS_W-1:0] TRACK_RST = POS_W'(FRAME_WIDTH / 2);
   localparam logic [CY_W:0]    HALF_H    = (CY_W + 1)'(REGION_HEIGHT / 2);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_CALC    = 10'b0000000010,
      ST_SQX     = 10'b0000000100,
      ST_SQY     = 10'b0000001000,
      ST_ROOT_GO = 10'b0000010000,
      ST_ROOT    = 10'b0000100000,
      ST_UPDATE  = 10'b0001000000,
      ST_CLOSE   = 10'b0010000000,
      ST_DIV     = 10'b0100000000,
      ST_EMIT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [AREA_W-1:0] area_min_ff;
   logic [POS_W-1:0]  near_window_ff, far_window_ff, center_x_ff, alt_low_ff, alt_high_ff;
   logic [BASE_W-1:0] base_speed_ff;

   logic                frame_last_ff;
   logic [LEFT_W-1:0]   left_ff;
   logic [TOP_W-1:0]    top_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;

   logic [CX_W-1:0]          cx_ff, cx_in;
   logic [CY_W-1:0]          cy_in;
   logic signed [MUL_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]          sq_sum_ff, sq_sum_in;
   logic [POS_W-1:0]         dist_ff, dist_in;

   logic [POS_W-1:0] tracked_x_ff, tracked_x_in;
   logic [POS_W-1:0] reference_x_ff, reference_x_in;
   logic [POS_W-1:0] alternate_x_ff, alternate_x_in;
   logic             main_flag_ff, main_flag_in;
   logic             blue_flag_ff, blue_flag_in;
   logic [POS_W-1:0] best_distance_ff, best_distance_in;
   logic [POS_W-1:0] best_center_ff, best_center_in;
   logic             have_best_ff, have_best_in;

   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [POS_W-1:0]        err_abs_ff, err_abs_in;
   logic [POS_W-1:0]        quot_ff, quot_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_W-1:0]   rsp_err_ff, rsp_err_in;
   logic signed [SPEED_W-1:0] rsp_ls_ff, rsp_ls_in, rsp_rs_ff, rsp_rs_in;
   logic                      rsp_main_ff, rsp_main_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   logic                    accept, better, in_near, in_far, alt_near;
   logic [POS_W-1:0]        ref_now, alt_mid, tx_new;
   logic signed [12:0]      cx_s, ref_s, alt_s, nw_s, fw_s;
   logic signed [ERR_W-1:0] err_raw;
   logic signed [ERR_W-1:0] e3;
   logic signed [12:0]      ls_w, rs_w;

   lbts_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   assign sqrt_req.start = (state_ff == ST_ROOT_GO);
   assign sqrt_req.value = sq_sum_ff;

   assign mul_p = mul_a * mul_b;

   always_comb begin
      mul_a = dx_ff;
      mul_b = dx_ff;
      case (state_ff)
         ST_SQY: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         ST_DIV: begin
            mul_a = $signed({2'b00, err_abs_ff});
            mul_b = RECIP3;
         end
         default: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
      endcase
   end

   always_comb begin
      cx_in = CX_W'({1'b0, left_ff} + {2'b00, width_ff[WIDTH_W-1:1]});
      cy_in = CY_W'({1'b0, top_ff} + {2'b00, height_ff[HEIGHT_W-1:1]});
      dx_in = $signed({1'b0, cx_in}) - $signed({2'b00, tracked_x_ff});
      dy_in = MUL_W'($signed({1'b0, cy_in}) - $signed(HALF_H));

      better  = !have_best_ff || (dist_ff < best_distance_ff);
      ref_now = better ? tracked_x_ff : reference_x_ff;
      cx_s    = $signed({2'b00, cx_ff});
      ref_s   = $signed({3'b000, ref_now});
      alt_s   = $signed({3'b000, alternate_x_ff});
      nw_s    = $signed({3'b000, near_window_ff});
      fw_s    = $signed({3'b000, far_window_ff});
      in_near  = main_flag_ff && (cx_s > ref_s - nw_s) && (cx_s < ref_s + nw_s);
      in_far   = main_flag_ff && ((cx_s > ref_s + fw_s) || (cx_s < ref_s - fw_s));
      alt_near = !main_flag_ff && (cx_s > alt_s - nw_s) && (cx_s < alt_s + nw_s);
      alt_mid  = (!in_near && in_far) ? ref_now : alternate_x_ff;

      tx_new  = have_best_ff ? best_center_ff : tracked_x_ff;
      err_raw = $signed({1'b0, center_x_ff}) - $signed({1'b0, tx_new});
      if (!blue_flag_ff) begin
         err_raw = -err_raw;
      end

      e3   = err_ff[ERR_W-1] ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
      ls_w = $signed({5'b00000, base_speed_ff}) - 13'(e3);
      rs_w = -($signed({5'b00000, base_speed_ff}) + 13'(e3));
   end

   always_comb begin
      state_in         = state_ff;
      sq_sum_in        = sq_sum_ff;
      dist_in          = dist_ff;
      tracked_x_in     = tracked_x_ff;
      reference_x_in   = reference_x_ff;
      alternate_x_in   = alternate_x_ff;
      main_flag_in     = main_flag_ff;
      blue_flag_in     = blue_flag_ff;
      best_distance_in = best_distance_ff;
      best_center_in   = best_center_ff;
      have_best_in     = have_best_ff;
      err_in           = err_ff;
      err_abs_in       = err_abs_ff;
      quot_in          = quot_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_err_in       = rsp_err_ff;
      rsp_ls_in        = rsp_ls_ff;
      rsp_rs_in        = rsp_rs_ff;
      rsp_main_in      = rsp_main_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_has_blob && (req_blob_area > area_min_ff)) begin
                  state_in = ST_CALC;
               end else if (req_frame_last) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CALC: begin
            state_in = ST_SQX;
         end
         ST_SQX: begin
            sq_sum_in = mul_p[SQ_W-1:0];
            state_in  = ST_SQY;
         end
         ST_SQY: begin
            sq_sum_in = sq_sum_ff + mul_p[SQ_W-1:0];
            state_in  = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_rsp.done) begin
               dist_in  = sqrt_rsp.root[ROOT_W-1] ? '1 : sqrt_rsp.root[POS_W-1:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (better) begin
               best_distance_in = dist_ff;
               best_center_in   = cx_ff[CX_W-1] ? '1 : cx_ff[POS_W-1:0];
               have_best_in     = 1'b1;
               reference_x_in   = tracked_x_ff;
            end
            if (in_near) begin
               blue_flag_in = 1'b1;
            end else if (in_far) begin
               main_flag_in = 1'b0;
               blue_flag_in = 1'b0;
            end else begin
               blue_flag_in = 1'b0;
               if (alt_near) begin
                  main_flag_in = 1'b1;
               end
            end
            if ((alt_mid > alt_high_ff) || (alt_mid < alt_low_ff)) begin
               alternate_x_in = center_x_ff;
            end else begin
               alternate_x_in = alt_mid;
            end
            state_in = frame_last_ff ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            tracked_x_in     = tx_new;
            have_best_in     = 1'b0;
            best_distance_in = '1;
            best_center_in   = '0;
            err_in           = err_raw;
            err_abs_in       = err_raw[ERR_W-1] ? POS_W'(-err_raw) : err_raw[POS_W-1:0];
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            quot_in  = POS_W'(mul_p >>> RECIP3_SHIFT);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_ls_in    = (ls_w > 13'sd511) ? 10'sd511 :
                              (ls_w < -13'sd512) ? -10'sd512 : ls_w[SPEED_W-1:0];
               rsp_rs_in    = (rs_w > 13'sd511) ? 10'sd511 :
                              (rs_w < -13'sd512) ? -10'sd512 : rs_w[SPEED_W-1:0];
               rsp_main_in  = main_flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         area_min_ff      <= AREA_MIN_RST;
         near_window_ff   <= NEAR_WINDOW_RST;
         far_window_ff    <= FAR_WINDOW_RST;
         center_x_ff      <= CENTER_X_RST;
         alt_low_ff       <= ALT_LOW_RST;
         alt_high_ff      <= ALT_HIGH_RST;
         base_speed_ff    <= BASE_SPEED_RST;
         tracked_x_ff     <= TRACK_RST;
         reference_x_ff   <= TRACK_RST;
         alternate_x_ff   <= '0;
         main_flag_ff     <= 1'b1;
         blue_flag_ff     <= 1'b1;
         best_distance_ff <= '1;
         best_center_ff   <= '0;
         have_best_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         tracked_x_ff     <= tracked_x_in;
         reference_x_ff   <= reference_x_in;
         alternate_x_ff   <= alternate_x_in;
         main_flag_ff     <= main_flag_in;
         blue_flag_ff     <= blue_flag_in;
         best_distance_ff <= best_distance_in;
         best_center_ff   <= best_center_in;
         have_best_ff     <= have_best_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_AREA_MIN:    area_min_ff    <= csr_wdata;
               CSR_NEAR_WINDOW: near_window_ff <= csr_wdata[POS_W-1:0];
               CSR_FAR_WINDOW:  far_window_ff  <= csr_wdata[POS_W-1:0];
               CSR_CENTER_X:    center_x_ff    <= csr_wdata[POS_W-1:0];
               CSR_ALT_LOW:     alt_low_ff     <= csr_wdata[POS_W-1:0];
               CSR_ALT_HIGH:    alt_high_ff    <= csr_wdata[POS_W-1:0];
               CSR_BASE_SPEED:  base_speed_ff  <= csr_wdata[BASE_W-1:0];
               default: begin
               end
            endcase
         end
      end
      if (accept) begin
         frame_last_ff <= req_frame_last;
         left_ff       <= req_blob_left;
         top_ff        <= req_blob_top;
         width_ff      <= req_blob_width;
         height_ff     <= req_blob_height;
      end
      if (state_ff == ST_CALC) begin
         cx_ff <= cx_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      sq_sum_ff  <= sq_sum_in;
      dist_ff    <= dist_in;
      err_ff     <= err_in;
      err_abs_ff <= err_abs_in;
      quot_ff    <= quot_in;
      rsp_err_ff <= rsp_err_in;
      rsp_ls_ff  <= rsp_ls_in;
      rsp_rs_ff  <= rsp_rs_in;
      rsp_main_ff <= rsp_main_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_steer_error = rsp_err_ff;
   assign rsp_left_speed  = rsp_ls_ff;
   assign rsp_right_speed = rsp_rs_ff;
   assign rsp_main_flag   = rsp_main_ff;

endmodule

// ----- test/line_blob_tracker_steering_top_tb.sv -----
`timescale 1ns / 100ps

module line_blob_tracker_steering_top_tb;
   import lbts_pkg::*;

   localparam int HALF_HEIGHT    = REGION_HEIGHT_DEF / 2;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_TARGET  = 760;
   localparam int FINAL_TARGET   = 900;

   typedef struct packed {
      logic                has_blob;
      logic [LEFT_W-1:0]   left;
      logic [TOP_W-1:0]    top;
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [AREA_W-1:0]   area;
      logic                last;
   } blob_item_t;

   localparam int ITEM_W = $bits(blob_item_t);

   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [SPEED_W-1:0] lspd;
      logic signed [SPEED_W-1:0] rspd;
      logic                      main_on;
   } steer_result_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;
   logic req_valid;
   logic req_stall;
   logic req_has_blob;
   logic [LEFT_W-1:0] req_blob_left;
   logic [TOP_W-1:0] req_blob_top;
   logic [WIDTH_W-1:0] req_blob_width;
   logic [HEIGHT_W-1:0] req_blob_height;
   logic [AREA_W-1:0] req_blob_area;
   logic req_frame_last;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [ERR_W-1:0] rsp_steer_error;
   logic signed [SPEED_W-1:0] rsp_left_speed;
   logic signed [SPEED_W-1:0] rsp_right_speed;
   logic rsp_main_flag;

   // Tracker copy kept in step with the accepted transfers.
   logic [AREA_W-1:0] lim_area;
   logic [POS_W-1:0]  win_near, win_far, aim_col, spare_lo, spare_hi;
   logic [BASE_W-1:0] cruise;
   logic [POS_W-1:0]  track_col, anchor_col, spare_col, near_dist, near_col;
   logic              on_main, on_blue, near_found;

   steer_result_t steer_q[$];
   steer_result_t due;

   bit idle_on = 1'b0;
   bit hold_rsp = 1'b0;
   int fails = 0;
   int n_items = 0;
   int n_results = 0;
   int n_frames = 0;
   int n_csr_writes = 0;
   int quiet_cycles = 0;

   line_blob_tracker_steering_top u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_has_blob    (req_has_blob),
      .req_blob_left   (req_blob_left),
      .req_blob_top    (req_blob_top),
      .req_blob_width  (req_blob_width),
      .req_blob_height (req_blob_height),
      .req_blob_area   (req_blob_area),
      .req_frame_last  (req_frame_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_steer_error (rsp_steer_error),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_main_flag   (rsp_main_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned root_floor(input int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic logic signed [SPEED_W-1:0] speed_clamp(input int v);
      if (v > 511) return 10'sd511;
      if (v < -512) return -10'sd512;
      return SPEED_W'(v);
   endfunction

   task automatic clear_tracker();
      lim_area = AREA_MIN_RST;
      win_near = NEAR_WINDOW_RST;
      win_far = FAR_WINDOW_RST;
      aim_col = CENTER_X_RST;
      spare_lo = ALT_LOW_RST;
      spare_hi = ALT_HIGH_RST;
      cruise = BASE_SPEED_RST;
      track_col = POS_W'(FRAME_WIDTH_DEF / 2);
      anchor_col = POS_W'(FRAME_WIDTH_DEF / 2);
      spare_col = '0;
      on_main = 1'b1;
      on_blue = 1'b1;
      near_dist = '1;
      near_col = '0;
      near_found = 1'b0;
   endtask

   task automatic track_blob(input blob_item_t it);
      int cx, cy, dx, dy, tx, rx, ax, nw, fw;
      int unsigned gap;
      if (it.area <= lim_area) return;
      cx = int'(it.left) + int'(it.width) / 2;
      cy = int'(it.top) + int'(it.height) / 2;
      tx = int'(track_col);
      dx = cx - tx;
      dy = cy - HALF_HEIGHT;
      gap = root_floor(dx * dx + dy * dy);
      if (gap > 1023) gap = 1023;
      if (!near_found || gap < near_dist) begin
         near_dist = POS_W'(gap);
         near_col = (cx > 1023) ? 10'd1023 : POS_W'(cx);
         near_found = 1'b1;
         anchor_col = track_col;
      end
      rx = int'(anchor_col);
      nw = int'(win_near);
      fw = int'(win_far);
      if (on_main && cx > rx - nw && cx < rx + nw) begin
         on_blue = 1'b1;
      end else if (on_main && (cx > rx + fw || cx < rx - fw)) begin
         spare_col = anchor_col;
         on_main = 1'b0;
         on_blue = 1'b0;
      end else begin
         on_blue = 1'b0;
         ax = int'(spare_col);
         if (!on_main && cx > ax - nw && cx < ax + nw) on_main = 1'b1;
      end
      if (spare_col > spare_hi || spare_col < spare_lo) spare_col = aim_col;
   endtask

   task automatic close_frame();
      int err, e3, aim, tx;
      steer_result_t r;
      if (near_found) track_col = near_col;
      near_found = 1'b0;
      near_dist = '1;
      near_col = '0;
      aim = int'(aim_col);
      tx = int'(track_col);
      err = aim - tx;
      if (!on_blue) err = -err;
      e3 = err / 3;
      r.err = ERR_W'(err);
      r.lspd = speed_clamp(int'(cruise) - e3);
      r.rspd = speed_clamp(-(int'(cruise) + e3));
      r.main_on = on_main;
      steer_q.push_back(r);
      n_frames++;
   endtask

   task automatic offer_item(input blob_item_t it);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_has_blob <= it.has_blob;
      req_blob_left <= it.left;
      req_blob_top <= it.top;
      req_blob_width <= it.width;
      req_blob_height <= it.height;
      req_blob_area <= it.area;
      req_frame_last <= it.last;
      do @(posedge clock); while (req_stall);
      if (it.has_blob) track_blob(it);
      if (it.last) close_frame();
      if (it.has_blob || it.last) n_items++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (steer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AREA_MIN:    lim_area = value[AREA_W-1:0];
         CSR_NEAR_WINDOW: win_near = value[POS_W-1:0];
         CSR_FAR_WINDOW:  win_far = value[POS_W-1:0];
         CSR_CENTER_X:    aim_col = value[POS_W-1:0];
         CSR_ALT_LOW:     spare_lo = value[POS_W-1:0];
         CSR_ALT_HIGH:    spare_hi = value[POS_W-1:0];
         CSR_BASE_SPEED:  cruise = value[BASE_W-1:0];
         default: ;
      endcase
      n_csr_writes++;
   endtask

   task automatic apply_settings(input int unsigned am, nw, fw, cx, lo, hi, bs);
      wait_idle();
      write_csr(CSR_AREA_MIN, am);
      write_csr(CSR_NEAR_WINDOW, nw);
      write_csr(CSR_FAR_WINDOW, fw);
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_ALT_LOW, lo);
      write_csr(CSR_ALT_HIGH, hi);
      write_csr(CSR_BASE_SPEED, bs);
   endtask

   task automatic apply_random_settings();
      int unsigned am;
      am = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
      apply_settings(am, $urandom_range(0, 200), $urandom_range(0, 400),
                     $urandom_range(0, 639), $urandom_range(0, 300),
                     $urandom_range(200, 639), $urandom_range(0, 255));
   endtask

   function automatic blob_item_t blob_at(input int cx, w, top, h, area, input bit last);
      blob_item_t it;
      int left;
      left = cx - w / 2;
      if (left < 0) left = 0;
      if (left > 1023) left = 1023;
      it.has_blob = 1'b1;
      it.left = LEFT_W'(left);
      it.top = TOP_W'(top);
      it.width = WIDTH_W'(w);
      it.height = HEIGHT_W'(h);
      it.area = AREA_W'(area);
      it.last = last;
      return it;
   endfunction

   function automatic blob_item_t no_blob(input bit last);
      blob_item_t it;
      it = '0;
      it.last = last;
      return it;
   endfunction

   function automatic blob_item_t noise_item();
      blob_item_t it;
      it = ITEM_W'($urandom);
      it.has_blob = 1'b0;
      it.last = 1'b0;
      return it;
   endfunction

   // Most blobs are placed relative to the tracked or alternate column so that
   // the near, far and return-to-line paths are all exercised.
   function automatic blob_item_t random_blob();
      blob_item_t it;
      int cx, w, nw, fw, am, area, pick;
      nw = int'(win_near);
      fw = int'(win_far);
      am = int'(lim_area);
      pick = $urandom_range(0, 9);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120);
      case (pick)
         0, 1, 2, 3: cx = int'(track_col) + int'($urandom_range(0, 2 * nw)) - nw;
         4: cx = ($urandom_range(0, 1) ? int'(track_col) + fw + int'($urandom_range(1, 150))
                                       : int'(track_col) - fw - int'($urandom_range(1, 150)));
         5, 6: cx = int'(spare_col) + int'($urandom_range(0, 2 * nw)) - nw;
         7: cx = $urandom_range(0, 959);
         default: cx = $urandom_range(0, 1534);
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2: area = $urandom_range(0, am);
         3: area = am;
         4: area = $urandom_range(0, 65535);
         default: area = am + $urandom_range(1, 3000);
      endcase
      if (area > 65535) area = 65535;
      if (pick == 9) begin
         it = ITEM_W'($urandom);
         it.area = AREA_W'(area);
      end else begin
         it = blob_at(cx, w, $urandom_range(0, 89), $urandom_range(0, 90), area, 1'b0);
      end
      it.has_blob = 1'b1;
      it.last = 1'b0;
      return it;
   endfunction

   task automatic send_random_frame();
      int n_blobs;
      bit ends_on_blob;
      blob_item_t it;
      n_blobs = $urandom_range(0, 4);
      ends_on_blob = (n_blobs > 0) && $urandom_range(0, 1);
      for (int i = 0; i < n_blobs; i++) begin
         if ($urandom_range(0, 11) == 0) offer_item(noise_item());
         it = random_blob();
         it.last = ends_on_blob && (i == n_blobs - 1);
         offer_item(it);
      end
      if (!ends_on_blob) begin
         it = ITEM_W'($urandom);
         it.has_blob = 1'b0;
         it.last = 1'b1;
         offer_item(it);
      end
   endtask

   task automatic test_area_gate_and_frame_ends();
      offer_item(blob_at(320, 40, 30, 30, 501, 1'b0));
      offer_item(blob_at(330, 40, 30, 30, 500, 1'b0));
      offer_item(blob_at(310, 40, 30, 30, 0, 1'b0));
      offer_item(no_blob(1'b1));
      offer_item(no_blob(1'b1));
      offer_item(no_blob(1'b0));
      offer_item(blob_at(350, 20, 40, 10, 65535, 1'b1));
   endtask

   task automatic test_line_switching();
      offer_item(blob_at(int'(track_col) + int'(win_far) + 60, 30, 20, 40, 2000, 1'b0));
      offer_item(blob_at(int'(spare_col), 30, 20, 40, 2000, 1'b1));
      offer_item(blob_at(int'(track_col) - 40, 20, 10, 50, 900, 1'b0));
      offer_item(blob_at(int'(track_col) + 40, 20, 10, 50, 900, 1'b0));
      offer_item(blob_at(int'(track_col) + 10, 20, 10, 50, 900, 1'b0));
      offer_item(no_blob(1'b1));
   endtask

   task automatic test_field_extremes();
      blob_item_t it;
      it = '1;
      offer_item(it);
      offer_item(blob_at(0, 0, 0, 0, 65535, 1'b1));
      it = '1;
      it.has_blob = 1'b0;
      offer_item(it);
   endtask

   task automatic test_speed_saturation();
      blob_item_t it;
      apply_settings(0, int'(NEAR_WINDOW_RST), int'(FAR_WINDOW_RST), 0, 0, 639, 255);
      it = '1;
      it.top = 45;
      it.height = 0;
      offer_item(it);
      offer_item(it);
      offer_item(blob_at(1023, 46, 40, 10, 1000, 1'b1));
   endtask

   task automatic test_register_settings();
      apply_settings(int'(AREA_MIN_RST), int'(NEAR_WINDOW_RST), int'(FAR_WINDOW_RST),
                     int'(CENTER_X_RST), int'(ALT_LOW_RST), int'(ALT_HIGH_RST),
                     int'(BASE_SPEED_RST));
      repeat (3) send_random_frame();
      apply_settings(0, 0, 0, 0, 0, 0, 0);
      repeat (3) send_random_frame();
      apply_settings(65535, 639, 639, 639, 639, 639, 255);
      repeat (3) send_random_frame();
      apply_random_settings();
      repeat (3) send_random_frame();
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      idle_on = 1'b0;
      hold_rsp = 1'b1;
      repeat (8) send_random_frame();
      wait_idle();
      idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (4) send_random_frame();
      wait_idle();
      repeat (4) send_random_frame();
   endtask

   task automatic test_random_traffic();
      int since_cfg;
      since_cfg = n_items;
      while (n_items < RANDOM_TARGET) begin
         if (n_items - since_cfg > 150) begin
            apply_random_settings();
            since_cfg = n_items;
         end
         send_random_frame();
      end
   endtask

   task automatic test_no_idling();
      wait_idle();
      idle_on = 1'b0;
      while (n_items < FINAL_TARGET) send_random_frame();
   endtask

   always begin
      @(negedge clock);
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         rsp_stall <= 1'b0;
         hold_rsp = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 17)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic report(input string what, input logic signed [15:0] e, a);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, e, a);
      fails++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (steer_q.size() == 0) begin
            $display("%0t: result transfer with nothing expected, error %0d",
                     $time, rsp_steer_error);
            fails++;
         end else begin
            due = steer_q.pop_front();
            if (due.err !== rsp_steer_error)
               report("steer_error", 16'(due.err), 16'(rsp_steer_error));
            if (due.lspd !== rsp_left_speed)
               report("left_speed", 16'(due.lspd), 16'(rsp_left_speed));
            if (due.rspd !== rsp_right_speed)
               report("right_speed", 16'(due.rspd), 16'(rsp_right_speed));
            if (due.main_on !== rsp_main_flag)
               report("main_flag", {15'd0, due.main_on}, {15'd0, rsp_main_flag});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results still due",
                  $time, quiet_cycles, steer_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_has_blob = 1'b0;
      req_blob_left = '0;
      req_blob_top = '0;
      req_blob_width = '0;
      req_blob_height = '0;
      req_blob_area = '0;
      req_frame_last = 1'b0;
      rsp_stall = 1'b0;
      clear_tracker();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      test_area_gate_and_frame_ends();
      test_line_switching();
      test_field_extremes();
      test_speed_saturation();
      test_register_settings();
      test_output_backpressure();
      test_sender_pause();
      test_random_traffic();
      test_no_idling();
      wait_idle();

      $display("Covered %0d item transfers in %0d frames, %0d results checked.",
               n_items, n_frames, n_results);
      $display("Register writes: %0d, including minimum, maximum and reset settings.",
               n_csr_writes);
      if (fails == 0 && steer_q.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
